// File: hw/rtl/fq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fq_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Request/response structs, operation codes and the sideband word that
// travels beside the divider pipeline.
// ----------------------------------------------------------------------------
package fq_pkg;

   localparam int WORD_W            = 32;
   localparam int FRACTION_BITS_DEF = 8;

   // Operation codes
   localparam logic [3:0] ACT_ADD = 4'd0;
   localparam logic [3:0] ACT_SUB = 4'd1;
   localparam logic [3:0] ACT_MUL = 4'd2;
   localparam logic [3:0] ACT_DIV = 4'd3;
   localparam logic [3:0] ACT_MIN = 4'd4;
   localparam logic [3:0] ACT_MAX = 4'd5;
   localparam logic [3:0] ACT_INC = 4'd6;
   localparam logic [3:0] ACT_DEC = 4'd7;
   localparam logic [3:0] ACT_I2F = 4'd8;
   localparam logic [3:0] ACT_F2I = 4'd9;

   typedef struct packed {
      logic [3:0]               action;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result;
      logic                     less;
      logic                     equal;
      logic                     greater;
      logic                     divide_by_zero;
   } rsp_type;

   // Sideband carried alongside the divider stages
   typedef struct packed {
      logic [WORD_W-1:0] alt_result;
      logic              is_div;
      logic              neg_quot;
      logic              div_zero;
      logic              less;
      logic              equal;
      logic              greater;
   } tag_type;

endpackage

// File: hw/rtl/fq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fq_div: pipelined unsigned restoring divider
// One quotient bit per register stage, NUM_W stages; a sideband tag and a
// valid bit travel with each division.
// ----------------------------------------------------------------------------
module fq_div import fq_pkg::*; #(
   parameter int NUM_W = WORD_W + FRACTION_BITS_DEF,
   parameter int DEN_W = WORD_W,
   parameter int TAG_W = $bits(tag_type)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             vld_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W-1:0] den_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign nq_prev  = in_num;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      // shift in next numerator bit, subtract when it fits
      assign trial  = {rem_prev, nq_prev[NUM_W-1]};
      assign ge     = (trial >= {1'b0, den_prev});
      assign diff   = trial - {1'b0, den_prev};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign nq_in  = {nq_prev[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         nq_ff[k]  <= nq_in;
         den_ff[k] <= den_prev;
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

// File: hw/rtl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: pipelined signed fixed-point ALU
// Add, subtract, multiply, divide, min, max, increment, decrement and
// integer/fixed conversions on 32-bit words with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on req_data when start is high and busy is low. busy is
//    always low: a new request may enter every clock cycle.
//  - Each request yields one response on rsp_data, marked by rsp_valid for
//    exactly one cycle, in request order.
//  - Every operation walks the same pipeline: input register, operand setup
//    and multiply stage, one divider stage per quotient bit
//    (32 + FRACTION_BITS), output register. The bit-serial divider
//    pipeline sets the length of this path; all operations walk the same
//    path so responses stay ordered.
//  - Throughput is one request per cycle.
//  - Synchronous reset empties the pipeline; no response is issued for
//    requests in flight at reset.
//  - The receiver cannot stall; responses must be taken when shown.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu import fq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int MAG_W = WORD_W + FRACTION_BITS;   // |numerator| width
   localparam int NUM_W = MAG_W + 1;                // signed numerator width
   localparam int PRD_W = 2 * WORD_W;
   localparam int RND_W = WORD_W + FRACTION_BITS;   // product bits that matter

   assign busy = 1'b0;

   // Stage 1: input register
   logic    s1_vld_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
   end

   // Stage 2: multiply, divider operand setup, simple results, flags
   logic signed [WORD_W-1:0] a_s;
   logic signed [WORD_W-1:0] b_s;
   logic signed [WORD_W:0]   b_half;
   logic signed [NUM_W-1:0]  num_s;
   logic [NUM_W-1:0]         num_neg;
   logic [MAG_W-1:0]         num_mag;
   logic [WORD_W-1:0]        den_mag;
   logic                     lt, eq, gt;
   logic [WORD_W-1:0]        simple_res;

   assign a_s = s1_req_ff.operand_a;
   assign b_s = s1_req_ff.operand_b;

   // b/2 truncated toward zero
   assign b_half  = $signed({b_s[WORD_W-1], b_s}
                            + {{WORD_W{1'b0}}, b_s[WORD_W-1]}) >>> 1;
   assign num_s   = ({{(NUM_W-WORD_W){a_s[WORD_W-1]}}, a_s} <<< FRACTION_BITS)
                  + {{(NUM_W-WORD_W-1){b_half[WORD_W]}}, b_half};
   assign num_neg = -num_s;
   assign num_mag = num_s[NUM_W-1] ? num_neg[MAG_W-1:0] : num_s[MAG_W-1:0];
   assign den_mag = b_s[WORD_W-1] ? (-b_s) : b_s;

   assign lt = (a_s < b_s);
   assign eq = (a_s == b_s);
   assign gt = (a_s > b_s);

   always_comb begin
      unique case (s1_req_ff.action)
         ACT_ADD: simple_res = a_s + b_s;
         ACT_SUB: simple_res = a_s - b_s;
         ACT_MIN: simple_res = lt ? a_s : b_s;
         ACT_MAX: simple_res = gt ? a_s : b_s;
         ACT_INC: simple_res = a_s + WORD_W'(1);
         ACT_DEC: simple_res = a_s - WORD_W'(1);
         ACT_I2F: simple_res = a_s <<< FRACTION_BITS;
         ACT_F2I: simple_res = a_s >>> FRACTION_BITS;
         default: simple_res = '0;
      endcase
   end

   logic                    s2_vld_ff;
   logic [3:0]              s2_act_ff;
   logic signed [PRD_W-1:0] s2_prod_ff;
   logic [MAG_W-1:0]        s2_num_ff;
   logic [WORD_W-1:0]       s2_den_ff;
   logic                    s2_neg_ff;
   logic                    s2_dz_ff;
   logic                    s2_lt_ff, s2_eq_ff, s2_gt_ff;
   logic [WORD_W-1:0]       s2_simple_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_act_ff    <= s1_req_ff.action;
      s2_prod_ff   <= a_s * b_s;
      s2_num_ff    <= num_mag;
      s2_den_ff    <= den_mag;
      s2_neg_ff    <= num_s[NUM_W-1] ^ b_s[WORD_W-1];
      s2_dz_ff     <= (s1_req_ff.action == ACT_DIV) && (b_s == '0);
      s2_lt_ff     <= lt;
      s2_eq_ff     <= eq;
      s2_gt_ff     <= gt;
      s2_simple_ff <= simple_res;
   end

   // Multiply rounding and sideband for the divider pipeline
   logic [RND_W-1:0] mul_round;
   tag_type          tag_in;

   assign mul_round = s2_prod_ff[RND_W-1:0] + (RND_W'(1) << (FRACTION_BITS - 1));

   always_comb begin
      tag_in.alt_result = (s2_act_ff == ACT_MUL) ? mul_round[RND_W-1:FRACTION_BITS]
                                                 : s2_simple_ff;
      tag_in.is_div     = (s2_act_ff == ACT_DIV);
      tag_in.neg_quot   = s2_neg_ff;
      tag_in.div_zero   = s2_dz_ff;
      tag_in.less       = s2_lt_ff;
      tag_in.equal      = s2_eq_ff;
      tag_in.greater    = s2_gt_ff;
   end

   // Divider stages
   logic             dv_valid;
   logic [MAG_W-1:0] dv_quot;
   tag_type          dv_tag;

   fq_div #(
      .NUM_W(MAG_W),
      .DEN_W(WORD_W),
      .TAG_W($bits(tag_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_vld_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_tag   (tag_in),
      .out_valid(dv_valid),
      .out_quot (dv_quot),
      .out_tag  (dv_tag)
   );

   // Final select and output register
   logic [WORD_W-1:0] quot_w;
   logic [WORD_W-1:0] res_in;

   assign quot_w = dv_tag.neg_quot ? (-dv_quot[WORD_W-1:0]) : dv_quot[WORD_W-1:0];

   always_comb begin
      priority if (dv_tag.div_zero) begin
         res_in = '0;
      end else if (dv_tag.is_div) begin
         res_in = quot_w;
      end else begin
         res_in = dv_tag.alt_result;
      end
   end

   logic    rsp_vld_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.result         <= res_in;
      rsp_ff.less           <= dv_tag.less;
      rsp_ff.equal          <= dv_tag.equal;
      rsp_ff.greater        <= dv_tag.greater;
      rsp_ff.divide_by_zero <= dv_tag.div_zero;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
